// ===== design/islr_pkg.sv =====
// Package: shared types and constants for the secondary link receiver.
package islr_pkg;

	localparam int MinVarLen = 12;
	localparam int MaxChunk  = 1024;
	localparam int CntW      = $clog2(MaxChunk + 1);
	localparam int HdrLen    = 13;
	localparam int QDepth    = 2;

	localparam logic [7:0] START_FIXED = 8'h10;
	localparam logic [7:0] START_VAR   = 8'h68;
	localparam logic [7:0] END_BYTE    = 8'h16;
	localparam logic [7:0] BCAST       = 8'd255;

	localparam logic [1:0] REG_STATION = 2'd0;
	localparam logic [1:0] REG_COMMON  = 2'd1;
	localparam logic [1:0] REG_DUAL    = 2'd2;

	typedef enum logic [3:0] {
		ACT_NONE = 4'd0, ACT_ACK_RESET = 4'd1, ACT_STATUS = 4'd2, ACT_END_INIT = 4'd3,
		ACT_REPEAT = 4'd4, ACT_CLASS1 = 4'd5, ACT_CLASS2 = 4'd6, ACT_NO_DATA = 4'd7,
		ACT_DELIVER = 4'd8, ACT_ACK_RP = 4'd9, ACT_NACK_RP = 4'd10
	} action_t;

	typedef enum logic [3:0] {
		ERR_OK = 4'd0, ERR_FIX_LEN = 4'd1, ERR_FIX_SUM = 4'd2, ERR_STATION = 4'd3,
		ERR_CTRL = 4'd4, ERR_FC = 4'd5, ERR_VAR_SHORT = 4'd6, ERR_VAR_FRAME = 4'd7,
		ERR_VAR_SUM = 4'd8, ERR_COMMON = 4'd9, ERR_START = 4'd10, ERR_STANDBY = 4'd11
	} err_t;

	// classified frame handed from front to back
	typedef struct packed {
		logic       standby;
		err_t       err;      // framing/address error, ERR_STANDBY, or ERR_OK
		logic       is_var;
		logic [7:0] ctrl;
		logic [7:0] type_id;
		logic [7:0] cot;
		logic       ioa_zero;
		logic [7:0] qrp;
	} frame_t;

	typedef struct packed {
		logic [3:0] action;
		logic [3:0] error_code;
		logic [6:0] reset_cot;
		logic [7:0] reset_qualifier;
		logic       event_buffer_clear;
		logic       acd_bit;
		logic       fcb_bit;
	} result_t;

endpackage

// ===== design/islr_front.sv =====
// Front end: byte absorption, frame checks and classification.
module islr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           rx_byte,
	input  logic                 chunk_end,
	input  logic                 host_is_master,
	input  logic [7:0]           station_q,
	input  logic [7:0]           common_q,
	input  logic                 dual_q,
	output logic                 frm_valid,
	output islr_pkg::frame_t     frm
);
	import islr_pkg::*;

	logic [CntW-1:0] cnt_q;
	logic [7:0]      hdr_q [HdrLen];
	logic [7:0]      sum_q, sumb_q;
	logic [7:0]      h [HdrLen];
	logic [7:0]      sum_n, sumb_n, last_n;
	logic [CntW-1:0] cnt_n;
	logic [8:0]      len;
	logic            sat;
	frame_t          f;

	assign sat = (cnt_q == CntW'(MaxChunk));

	always_comb begin
		for (int i = 0; i < HdrLen; i++)
			h[i] = (!sat && cnt_q == CntW'(i)) ? rx_byte : hdr_q[i];
		len    = {1'b0, h[1]};
		sum_n  = sum_q;
		sumb_n = sumb_q;
		cnt_n  = sat ? cnt_q : cnt_q + 1'b1;
		last_n = rx_byte;
		if (!sat && cnt_q >= CntW'(4)) begin
			if (cnt_q < CntW'(len) + CntW'(4))
				sum_n = sum_q + rx_byte;
			else if (cnt_q == CntW'(len) + CntW'(4))
				sumb_n = rx_byte;
		end
	end

	always_comb begin
		f          = '0;
		f.err      = ERR_OK;
		f.ctrl     = '0;
		f.type_id  = h[6];
		f.cot      = h[8];
		f.ioa_zero = (h[10] == 8'd0) && (h[11] == 8'd0);
		f.qrp      = h[12];
		if (dual_q && !host_is_master) begin
			f.standby = 1'b1;
			f.err     = ERR_STANDBY;
		end else if (h[0] == START_FIXED) begin
			f.ctrl = h[1];
			if (cnt_n < CntW'(5) || h[4] != END_BYTE || cnt_n >= CntW'(10))
				f.err = ERR_FIX_LEN;
			else if (8'(h[1] + h[2]) != h[3])
				f.err = ERR_FIX_SUM;
			else if (h[2] != station_q && h[2] != BCAST)
				f.err = ERR_STATION;
		end else if (h[0] == START_VAR) begin
			f.is_var = 1'b1;
			f.ctrl   = h[4];
			if (cnt_n < CntW'(MinVarLen) || cnt_n < CntW'(len) + CntW'(6))
				f.err = ERR_VAR_SHORT;
			else if (h[3] != START_VAR || h[1] != h[2] || last_n != END_BYTE)
				f.err = ERR_VAR_FRAME;
			else if (sum_n != sumb_n)
				f.err = ERR_VAR_SUM;
			else if (h[5] != station_q && h[5] != BCAST)
				f.err = ERR_STATION;
			else if (h[9] != common_q && h[9] != BCAST)
				f.err = ERR_COMMON;
		end else begin
			f.err = ERR_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			sumb_q <= '0;
			for (int i = 0; i < HdrLen; i++) hdr_q[i] <= '0;
		end else if (in_valid) begin
			if (chunk_end) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				sumb_q <= '0;
				for (int i = 0; i < HdrLen; i++) hdr_q[i] <= '0;
			end else begin
				cnt_q  <= cnt_n;
				sum_q  <= sum_n;
				sumb_q <= sumb_n;
				for (int i = 0; i < HdrLen; i++) hdr_q[i] <= h[i];
			end
		end
	end

	assign frm_valid = in_valid && chunk_end;
	assign frm       = f;

endmodule

// ===== design/islr_queue.sv =====
// Short queue between classifier and link-state back end.
module islr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  islr_pkg::frame_t     wr_data,
	output logic                 full,
	output logic                 rd_valid,
	input  logic                 rd_en,
	output islr_pkg::frame_t     rd_data
);
	import islr_pkg::*;

	localparam int PW = $clog2(QDepth);

	frame_t        mem_q [QDepth];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full     = (cnt_q == (PW+1)'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

endmodule

// ===== design/islr_back.sv =====
// Back end: function-code decode, link state and result register.
module islr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frm_valid,
	input  islr_pkg::frame_t     frm,
	output logic                 frm_take,
	output logic                 out_valid,
	input  logic                 out_stall,
	output islr_pkg::result_t    res
);
	import islr_pkg::*;

	logic       fcb_q, acd_q, init_q;
	logic [1:0] mode_q;
	logic       fcb_n, acd_n, init_n;
	logic [1:0] mode_n;
	result_t    r, res_q;
	logic       vld_q;
	logic [3:0] fc;
	logic       bit5, pend;

	assign fc   = frm.ctrl[3:0];
	assign bit5 = frm.ctrl[5];
	assign pend = init_q || (mode_q == 2'd1);

	always_comb begin
		fcb_n  = fcb_q;
		acd_n  = acd_q;
		init_n = init_q;
		mode_n = mode_q;
		r      = '0;
		r.action     = ACT_NONE;
		r.error_code = frm.err;
		if (frm.standby) begin
			init_n = 1'b1;
		end else if (frm.err != ERR_OK) begin
		end else if (!frm.is_var) begin
			unique case (fc)
				4'd0: if ((frm.ctrl & 8'h50) != 8'h40) r.error_code = ERR_CTRL;
					else begin
						fcb_n = 1'b0;
						if (pend) acd_n = 1'b1;
						r.action = ACT_ACK_RESET;
					end
				4'd8, 4'd9: if ((frm.ctrl & 8'h50) != 8'h40) r.error_code = ERR_CTRL;
					else r.action = ACT_STATUS;
				4'd10: if ((frm.ctrl & 8'h50) != 8'h50) r.error_code = ERR_CTRL;
					else if (pend) begin
						acd_n = 1'b0; init_n = 1'b0; mode_n = 2'd0; fcb_n = bit5;
						r.action = ACT_END_INIT;
					end else if (bit5 == fcb_q) r.action = ACT_REPEAT;
					else begin
						fcb_n = ~fcb_q; r.action = ACT_CLASS1;
					end
				4'd11: if ((frm.ctrl & 8'h50) != 8'h50) r.error_code = ERR_CTRL;
					else if (bit5 == fcb_q) r.action = ACT_REPEAT;
					else begin
						fcb_n = ~fcb_q;
						if (pend) begin acd_n = 1'b1; r.action = ACT_NO_DATA; end
						else r.action = ACT_CLASS2;
					end
				default: r.error_code = ERR_FC;
			endcase
		end else if (fc == 4'd3) begin
			if ((frm.ctrl & 8'hD0) != 8'h50) r.error_code = ERR_CTRL;
			else if (bit5 == fcb_q) r.action = ACT_REPEAT;
			else begin fcb_n = ~fcb_q; r.action = ACT_DELIVER; end
		end else if (fc != 4'd1) begin
			r.error_code = ERR_FC;
		end else begin
			r.action = ACT_ACK_RP;
			if ((frm.ctrl & 8'hD0) != 8'h40) begin
				r.error_code = ERR_CTRL; r.action = ACT_NACK_RP;
			end
			if (frm.type_id == 8'd105) begin
				r.reset_qualifier = frm.qrp;
				if ((frm.cot & 8'h3F) == 8'd6) begin
					if (!frm.ioa_zero) r.reset_cot = 7'h6F;
					else begin
						r.reset_cot = 7'd7;
						if (frm.qrp == 8'd1 || frm.qrp == 8'd2) begin
							mode_n = frm.qrp[1:0];
							r.event_buffer_clear = 1'b1;
						end
					end
				end else r.reset_cot = 7'h6D;
			end
			fcb_n = ~fcb_q;
		end
		r.acd_bit = acd_n;
		r.fcb_bit = fcb_n;
	end

	assign frm_take  = frm_valid && (!vld_q || !out_stall);
	assign out_valid = vld_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (frm_take) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcb_q  <= 1'b0;
			acd_q  <= 1'b0;
			init_q <= 1'b1;
			mode_q <= 2'd0;
			vld_q  <= 1'b0;
		end else begin
			if (frm_take) begin
				fcb_q  <= fcb_n;
				acd_q  <= acd_n;
				init_q <= init_n;
				mode_q <= mode_n;
				vld_q  <= 1'b1;
			end else if (!out_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/iec101_secondary_link_receiver_top.sv =====
// Top level: IEC 101 unbalanced secondary link receiver.
// Throughput: one byte item per cycle unless in_stall (queue full) holds it. Non-final
// bytes give no result. A chunk-end item yields its result through front classify,
// the 2-entry queue and back decode into the output register, which out_stall can hold.
// Reset clears chunk state, link state (local init pending) and registers
// (station and common address 1, dual host 0).
module iec101_secondary_link_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       chunk_end,
	input  logic       host_is_master,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] action,
	output logic [3:0] error_code,
	output logic [6:0] reset_cot,
	output logic [7:0] reset_qualifier,
	output logic       event_buffer_clear,
	output logic       acd_bit,
	output logic       fcb_bit,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import islr_pkg::*;

	logic [7:0] station_q, common_q;
	logic       dual_q;
	logic       acc, f_valid, q_full, q_valid, q_take;
	frame_t     f, qf;
	result_t    r;
	logic [1:0] ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'd1;
			common_q  <= 8'd1;
			dual_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_STATION: station_q <= pwdata[7:0];
				REG_COMMON:  common_q  <= pwdata[7:0];
				REG_DUAL:    dual_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_STATION: prdata = {24'd0, station_q};
			REG_COMMON:  prdata = {24'd0, common_q};
			REG_DUAL:    prdata = {31'd0, dual_q};
			default:     prdata = '0;
		endcase
	end

	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;

	islr_front u_front (
		.clk, .arst_n, .in_valid(acc), .rx_byte, .chunk_end, .host_is_master,
		.station_q, .common_q, .dual_q, .frm_valid(f_valid), .frm(f)
	);

	islr_queue u_queue (
		.clk, .arst_n, .wr_en(f_valid), .wr_data(f), .full(q_full),
		.rd_valid(q_valid), .rd_en(q_take), .rd_data(qf)
	);

	islr_back u_back (
		.clk, .arst_n, .frm_valid(q_valid), .frm(qf), .frm_take(q_take),
		.out_valid, .out_stall, .res(r)
	);

	assign action             = r.action;
	assign error_code         = r.error_code;
	assign reset_cot          = r.reset_cot;
	assign reset_qualifier    = r.reset_qualifier;
	assign event_buffer_clear = r.event_buffer_clear;
	assign acd_bit            = r.acd_bit;
	assign fcb_bit            = r.fcb_bit;

endmodule
